FILE: hw/rtl/pid_ds_pkg.sv
// ----------------------------------------------------------------------------
// pid_ds_pkg
// Shared widths, reset values, register codes and reciprocal constants for
// the PID differential steering unit.
// ----------------------------------------------------------------------------
package pid_ds_pkg;

  localparam int PosW     = 13;
  localparam int ErrW     = 14;
  localparam int DerivW   = 15;
  localparam int Deriv3W  = 17;
  localparam int HalfW    = 16;
  localparam int SpeedW   = 8;
  localparam int SteerW   = 9;
  localparam int TermW    = 17;

  localparam int CfgAddrW = 1;
  localparam int CfgDataW = 13;

  localparam int SumWidthDefault = 32;

  localparam logic [PosW-1:0]   SetpointReset = 13'd3200;
  localparam logic [SpeedW-1:0] MaxSpeedReset = 8'd255;

  typedef enum logic [CfgAddrW-1:0] {
    RegSetpoint = 1'b0,
    RegMaxSpeed = 1'b1
  } cfg_reg_e;

  // error / 10: floor(a * 6554 / 2^16) is exact for a < 2^14
  localparam int ErrMagW   = 13;
  localparam int ErrRecip  = 6554;
  localparam int ErrRecipW = 13;
  localparam int ErrShift  = 16;
  localparam int ErrQuoW   = 10;

  // integral / 10000 as (x >> 4) / 625; magnitudes beyond the cap saturate
  // the drive term anyway, so the magnitude is clamped to 28 bits
  localparam int SumMagW   = 28;
  localparam int SumMagCap = 268435455;
  localparam int SumPreSh  = 4;
  localparam int SumYW     = 24;
  localparam int SumRecip  = 27487791;
  localparam int SumRecipW = 25;
  localparam int SumShift  = 34;
  localparam int SumQuoW   = 15;

  typedef struct packed {
    logic mag_en;
    logic mul_en;
  } pid_ds_adv_t;

endpackage

FILE: hw/rtl/pid_ds_integrator.sv
// ----------------------------------------------------------------------------
// pid_ds_integrator
// Error, derivative and saturating integral; holds the controller state.
// ----------------------------------------------------------------------------
module pid_ds_integrator #(
  parameter int SumWidth = pid_ds_pkg::SumWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              take_i,
  input  logic [pid_ds_pkg::PosW-1:0]       position_i,
  input  logic [pid_ds_pkg::PosW-1:0]       setpoint_i,
  output logic signed [pid_ds_pkg::ErrW-1:0]   err_o,
  output logic signed [pid_ds_pkg::DerivW-1:0] deriv_o,
  output logic signed [SumWidth-1:0]        sum_o
);

  localparam int SumExtW = SumWidth + 1;
  localparam logic signed [SumWidth-1:0] SumMax = {1'b0, {(SumWidth-1){1'b1}}};
  localparam logic signed [SumWidth-1:0] SumMin = {1'b1, {(SumWidth-1){1'b0}}};

  logic signed [pid_ds_pkg::ErrW-1:0]   err_d, err_q;
  logic signed [pid_ds_pkg::DerivW-1:0] deriv_d, deriv_q;
  logic signed [SumWidth-1:0]           sum_d, sum_q;
  logic signed [SumExtW-1:0]            sum_ext;

  always_comb begin
    err_d   = $signed({1'b0, position_i}) - $signed({1'b0, setpoint_i});
    deriv_d = pid_ds_pkg::DerivW'(err_d) - pid_ds_pkg::DerivW'(err_q);
    sum_ext = SumExtW'(sum_q) + SumExtW'(err_d);
    if (sum_ext[SumWidth] != sum_ext[SumWidth-1]) begin
      sum_d = sum_ext[SumWidth] ? SumMin : SumMax;
    end else begin
      sum_d = sum_ext[SumWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= '0;
      sum_q <= '0;
    end else if (take_i) begin
      err_q <= err_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      deriv_q <= deriv_d;
    end
  end

  assign err_o   = err_q;
  assign deriv_o = deriv_q;
  assign sum_o   = sum_q;

endmodule

FILE: hw/rtl/pid_ds_divider.sv
// ----------------------------------------------------------------------------
// pid_ds_divider
// Two stages: magnitudes and derivative scaling, then reciprocal multiplies
// for the proportional and integral quotients.
// ----------------------------------------------------------------------------
module pid_ds_divider #(
  parameter int SumWidth = pid_ds_pkg::SumWidthDefault
) (
  input  logic                                   clk_i,
  input  pid_ds_pkg::pid_ds_adv_t                adv_i,
  input  logic signed [pid_ds_pkg::ErrW-1:0]     err_i,
  input  logic signed [pid_ds_pkg::DerivW-1:0]   deriv_i,
  input  logic signed [SumWidth-1:0]             sum_i,
  output logic signed [pid_ds_pkg::ErrQuoW:0]    err_quo_o,
  output logic signed [pid_ds_pkg::SumQuoW:0]    sum_quo_o,
  output logic signed [pid_ds_pkg::HalfW-1:0]    half_o
);

  localparam int ErrProdW = pid_ds_pkg::ErrMagW + pid_ds_pkg::ErrRecipW;
  localparam int SumProdW = pid_ds_pkg::SumYW + pid_ds_pkg::SumRecipW;

  // magnitude stage
  logic signed [pid_ds_pkg::ErrW-1:0]    err_abs;
  logic [pid_ds_pkg::ErrMagW-1:0]        err_mag_d, err_mag_q;
  logic                                  err_neg_q;
  logic [SumWidth-1:0]                   sum_abs;
  logic [pid_ds_pkg::SumMagW-1:0]        sum_mag;
  logic [pid_ds_pkg::SumYW-1:0]          sum_y_d, sum_y_q;
  logic                                  sum_neg_q;
  logic signed [pid_ds_pkg::Deriv3W-1:0] deriv3, deriv3_adj;
  logic signed [pid_ds_pkg::HalfW-1:0]   half_d, half_c_q, half_m_q;

  // multiply stage
  logic [ErrProdW-1:0]                   err_prod;
  logic [SumProdW-1:0]                   sum_prod;
  logic [pid_ds_pkg::ErrQuoW-1:0]        err_quo_mag;
  logic [pid_ds_pkg::SumQuoW-1:0]        sum_quo_mag;
  logic signed [pid_ds_pkg::ErrQuoW:0]   err_quo_d, err_quo_q;
  logic signed [pid_ds_pkg::SumQuoW:0]   sum_quo_d, sum_quo_q;

  always_comb begin
    err_abs   = err_i[pid_ds_pkg::ErrW-1] ? -err_i : err_i;
    err_mag_d = pid_ds_pkg::ErrMagW'(err_abs);
    sum_abs   = sum_i[SumWidth-1] ? SumWidth'(-sum_i) : SumWidth'(sum_i);
    if (sum_abs > SumWidth'(pid_ds_pkg::SumMagCap)) begin
      sum_mag = '1;
    end else begin
      sum_mag = pid_ds_pkg::SumMagW'(sum_abs);
    end
    sum_y_d    = sum_mag[pid_ds_pkg::SumMagW-1:pid_ds_pkg::SumPreSh];
    deriv3     = (pid_ds_pkg::Deriv3W'(deriv_i) <<< 1) + pid_ds_pkg::Deriv3W'(deriv_i);
    deriv3_adj = deriv3;
    if (deriv3[pid_ds_pkg::Deriv3W-1]) begin
      deriv3_adj = deriv3 + pid_ds_pkg::Deriv3W'(1);
    end
    half_d = pid_ds_pkg::HalfW'(deriv3_adj >>> 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.mag_en) begin
      err_mag_q <= err_mag_d;
      err_neg_q <= err_i[pid_ds_pkg::ErrW-1];
      sum_y_q   <= sum_y_d;
      sum_neg_q <= sum_i[SumWidth-1];
      half_c_q  <= half_d;
    end
  end

  always_comb begin
    err_prod    = err_mag_q * pid_ds_pkg::ErrRecipW'(pid_ds_pkg::ErrRecip);
    sum_prod    = sum_y_q * pid_ds_pkg::SumRecipW'(pid_ds_pkg::SumRecip);
    err_quo_mag = err_prod[pid_ds_pkg::ErrShift +: pid_ds_pkg::ErrQuoW];
    sum_quo_mag = sum_prod[pid_ds_pkg::SumShift +: pid_ds_pkg::SumQuoW];
    err_quo_d   = err_neg_q ? -$signed({1'b0, err_quo_mag}) : $signed({1'b0, err_quo_mag});
    sum_quo_d   = sum_neg_q ? -$signed({1'b0, sum_quo_mag}) : $signed({1'b0, sum_quo_mag});
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.mul_en) begin
      err_quo_q <= err_quo_d;
      sum_quo_q <= sum_quo_d;
      half_m_q  <= half_c_q;
    end
  end

  assign err_quo_o = err_quo_q;
  assign sum_quo_o = sum_quo_q;
  assign half_o    = half_m_q;

endmodule

FILE: hw/rtl/pid_ds_mixer.sv
// ----------------------------------------------------------------------------
// pid_ds_mixer
// Sum of the three terms, clamp to the speed limit and wheel speed split;
// holds the result register.
// ----------------------------------------------------------------------------
module pid_ds_mixer (
  input  logic                                 clk_i,
  input  logic                                 take_i,
  input  logic [pid_ds_pkg::SpeedW-1:0]        max_speed_i,
  input  logic signed [pid_ds_pkg::ErrQuoW:0]  err_quo_i,
  input  logic signed [pid_ds_pkg::SumQuoW:0]  sum_quo_i,
  input  logic signed [pid_ds_pkg::HalfW-1:0]  half_i,
  output logic [pid_ds_pkg::SpeedW-1:0]        left_speed_o,
  output logic [pid_ds_pkg::SpeedW-1:0]        right_speed_o,
  output logic signed [pid_ds_pkg::SteerW-1:0] steer_o
);

  logic signed [pid_ds_pkg::TermW-1:0]  term, lim, sat;
  logic [pid_ds_pkg::SpeedW-1:0]        left_d, right_d, left_q, right_q;
  logic signed [pid_ds_pkg::SteerW-1:0] steer_d, steer_q;

  always_comb begin
    term = pid_ds_pkg::TermW'(err_quo_i) + pid_ds_pkg::TermW'(sum_quo_i)
         + pid_ds_pkg::TermW'(half_i);
    lim  = pid_ds_pkg::TermW'(max_speed_i);
    if (term > lim) begin
      sat = lim;
    end else if (term < -lim) begin
      sat = -lim;
    end else begin
      sat = term;
    end
    if (sat[pid_ds_pkg::TermW-1]) begin
      left_d  = pid_ds_pkg::SpeedW'(lim + sat);
      right_d = max_speed_i;
    end else begin
      left_d  = max_speed_i;
      right_d = pid_ds_pkg::SpeedW'(lim - sat);
    end
    steer_d = pid_ds_pkg::SteerW'(sat);
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      steer_q <= steer_d;
    end
  end

  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign steer_o       = steer_q;

endmodule

FILE: hw/rtl/pid_differential_steering_unit.sv
// ----------------------------------------------------------------------------
// pid_differential_steering_unit
// PID steering for a differential drive: one position word in, one pair of
// wheel speeds and the clamped steering term out.
// ----------------------------------------------------------------------------
// Stages: input, error, magnitude, multiply and output registers, in order.
// Throughput: one word per cycle through a five-register pipeline when not
// stalled; each stage advances independently, so bubbles close up while the
// output stalls. Reset: asynchronous, clears all valid bits, the previous
// error and the integral, and loads setpoint 3200 and max speed 255.
module pid_differential_steering_unit #(
  parameter int SumWidth = pid_ds_pkg::SumWidthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pid_ds_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [pid_ds_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [pid_ds_pkg::PosW-1:0]          position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [pid_ds_pkg::SpeedW-1:0]        left_speed_o,
  output logic [pid_ds_pkg::SpeedW-1:0]        right_speed_o,
  output logic signed [pid_ds_pkg::SteerW-1:0] steer_o
);

  localparam int NumStages = 5;
  localparam int StIn  = 0;
  localparam int StErr = 1;
  localparam int StMag = 2;
  localparam int StMul = 3;
  localparam int StOut = 4;

  logic [NumStages-1:0]                 valid_d, valid_q, rdy, take;
  logic [pid_ds_pkg::PosW-1:0]          pos_q;
  logic [pid_ds_pkg::PosW-1:0]          setpoint_q;
  logic [pid_ds_pkg::SpeedW-1:0]        max_speed_q;
  logic signed [pid_ds_pkg::ErrW-1:0]   err;
  logic signed [pid_ds_pkg::DerivW-1:0] deriv;
  logic signed [SumWidth-1:0]           sum;
  logic signed [pid_ds_pkg::ErrQuoW:0]  err_quo;
  logic signed [pid_ds_pkg::SumQuoW:0]  sum_quo;
  logic signed [pid_ds_pkg::HalfW-1:0]  half;
  pid_ds_pkg::pid_ds_adv_t              adv;

  always_comb begin
    rdy[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    take[StIn]    = in_valid_i && rdy[StIn];
    valid_d[StIn] = rdy[StIn] ? in_valid_i : valid_q[StIn];
    for (int k = 1; k < NumStages; k++) begin
      take[k]    = valid_q[k-1] && rdy[k];
      valid_d[k] = rdy[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  assign adv.mag_en = take[StMag];
  assign adv.mul_en = take[StMul];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      setpoint_q  <= pid_ds_pkg::SetpointReset;
      max_speed_q <= pid_ds_pkg::MaxSpeedReset;
    end else begin
      valid_q <= valid_d;
      if (cfg_we_i) begin
        case (pid_ds_pkg::cfg_reg_e'(cfg_addr_i))
          pid_ds_pkg::RegSetpoint: setpoint_q  <= cfg_wdata_i;
          pid_ds_pkg::RegMaxSpeed: max_speed_q <= cfg_wdata_i[pid_ds_pkg::SpeedW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[StIn]) begin
      pos_q <= position_i;
    end
  end

  pid_ds_integrator #(
    .SumWidth(SumWidth)
  ) u_integrator (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take[StErr]),
    .position_i (pos_q),
    .setpoint_i (setpoint_q),
    .err_o      (err),
    .deriv_o    (deriv),
    .sum_o      (sum)
  );

  pid_ds_divider #(
    .SumWidth(SumWidth)
  ) u_divider (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .err_i     (err),
    .deriv_i   (deriv),
    .sum_i     (sum),
    .err_quo_o (err_quo),
    .sum_quo_o (sum_quo),
    .half_o    (half)
  );

  pid_ds_mixer u_mixer (
    .clk_i         (clk_i),
    .take_i        (take[StOut]),
    .max_speed_i   (max_speed_q),
    .err_quo_i     (err_quo),
    .sum_quo_i     (sum_quo),
    .half_i        (half),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o),
    .steer_o       (steer_o)
  );

  assign in_ready_o  = rdy[StIn];
  assign out_valid_o = valid_q[StOut];

endmodule

FILE: hw/rtl/pid_ds_checker.sv
// ----------------------------------------------------------------------------
// pid_ds_checker
// Port-level checks on the result channel of the steering unit.
// ----------------------------------------------------------------------------
module pid_ds_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [pid_ds_pkg::SpeedW-1:0]        left_speed_o,
  input logic [pid_ds_pkg::SpeedW-1:0]        right_speed_o,
  input logic signed [pid_ds_pkg::SteerW-1:0] steer_o
);

  localparam int DiffW = pid_ds_pkg::SpeedW + 2;

  logic [DiffW-1:0] speed_diff;
  logic [DiffW-1:0] steer_ext;

  assign speed_diff = DiffW'(left_speed_o) - DiffW'(right_speed_o);
  assign steer_ext  = DiffW'(steer_o);

  ast_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  ast_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(steer_o) && $stable(left_speed_o)
      && $stable(right_speed_o))
    else $error("result word changed while stalled");

  ast_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> speed_diff == steer_ext)
    else $error("wheel speed difference does not match steer");

  ast_steer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> steer_o != $signed(9'h100))
    else $error("steer outside the speed limit range");

endmodule

bind pid_differential_steering_unit pid_ds_checker u_pid_ds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .left_speed_o  (left_speed_o),
  .right_speed_o (right_speed_o),
  .steer_o       (steer_o)
);

FILE: verif/pid_differential_steering_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_differential_steering_unit_checker
// Watches the configuration port and both word channels of the steering unit.
// For each accepted position word, it updates its own copy of the PID state
// and queues the wheel command that the word should produce. Each accepted
// output word is compared field by field with the oldest queued command.
// The mismatch count and the number of outstanding commands go to the top.
// ----------------------------------------------------------------------------
module pid_differential_steering_unit_checker #(
  parameter int SumWidth = pid_ds_pkg::SumWidthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pid_ds_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [pid_ds_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic [pid_ds_pkg::PosW-1:0]          position_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic [pid_ds_pkg::SpeedW-1:0]        left_speed_i,
  input  logic [pid_ds_pkg::SpeedW-1:0]        right_speed_i,
  input  logic signed [pid_ds_pkg::SteerW-1:0] steer_i,
  output int unsigned                          mismatch_cnt_o,
  output int unsigned                          pending_o
);
  import pid_ds_pkg::*;

  typedef struct packed {
    logic [SpeedW-1:0]        left;
    logic [SpeedW-1:0]        right;
    logic signed [SteerW-1:0] steer;
  } wheel_cmd_t;

  localparam longint IntegralMax = (longint'(1) <<< (SumWidth - 1)) - 1;
  localparam longint IntegralMin = -IntegralMax - 1;

  logic [PosW-1:0]            setpoint_q;
  logic [SpeedW-1:0]          max_speed_q;
  logic signed [15:0]         prev_error_q;
  logic signed [SumWidth-1:0] integral_q;
  wheel_cmd_t                 wheel_cmd_q[$];
  int unsigned                mismatch_cnt;

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  function automatic wheel_cmd_t steer_update(input logic [PosW-1:0] position);
    longint     error;
    longint     deriv;
    longint     integral;
    longint     term;
    longint     limit;
    wheel_cmd_t cmd;
    error    = longint'(position) - longint'(setpoint_q);
    deriv    = error - longint'(prev_error_q);
    integral = longint'(integral_q);
    // saturate the integral at its register width
    if (error > 0 && integral > IntegralMax - error) begin
      integral = IntegralMax;
    end else if (error < 0 && integral < IntegralMin - error) begin
      integral = IntegralMin;
    end else begin
      integral = integral + error;
    end
    integral_q   = SumWidth'(integral);
    prev_error_q = 16'(error);
    term  = error / 10 + integral / 10000 + (deriv * 3) / 2;
    limit = longint'(max_speed_q);
    if (term > limit) term = limit;
    if (term < -limit) term = -limit;
    cmd.steer = SteerW'(term);
    cmd.left  = (term < 0) ? SpeedW'(limit + term) : SpeedW'(limit);
    cmd.right = (term < 0) ? SpeedW'(limit) : SpeedW'(limit - term);
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    wheel_cmd_t want;
    wheel_cmd_t got;
    if (!rst_ni) begin
      setpoint_q   = SetpointReset;
      max_speed_q  = MaxSpeedReset;
      prev_error_q = '0;
      integral_q   = '0;
      wheel_cmd_q.delete();
      mismatch_cnt = 0;
    end else begin
      got.left  = left_speed_i;
      got.right = right_speed_i;
      got.steer = steer_i;
      if (out_valid_i && out_ready_i) begin
        if (wheel_cmd_q.size() == 0) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: wheel word with none expected: left %0d right %0d steer %0d",
                     $time, got.left, got.right, got.steer);
          end
          mismatch_cnt++;
        end else begin
          want = wheel_cmd_q.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.steer !== want.steer) begin
            if (mismatch_cnt < 10) begin
              $display("%0t: wheel word mismatch (expected/actual): left %0d/%0d right %0d/%0d steer %0d/%0d",
                       $time, want.left, got.left, want.right, got.right,
                       want.steer, got.steer);
            end
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        wheel_cmd_q.push_back(steer_update(position_i));
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          RegSetpoint: setpoint_q  = cfg_wdata_i[PosW-1:0];
          RegMaxSpeed: max_speed_q = cfg_wdata_i[SpeedW-1:0];
          default: ;
        endcase
      end
    end
    pending_o      <= wheel_cmd_q.size();
    mismatch_cnt_o <= mismatch_cnt;
  end

endmodule

FILE: verif/pid_differential_steering_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_differential_steering_unit_test
// Drives position words into the steering unit under several setpoint and
// speed settings: a directed pass over the extremes, random phases near and
// far from the setpoint with idle bursts on both channels, and a final run
// at full rate with the error held at both of its extremes.
// ----------------------------------------------------------------------------
module pid_differential_steering_unit_test;
  import pid_ds_pkg::*;

  localparam int WatchdogLimit = 1000;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [CfgAddrW-1:0]         cfg_addr;
  logic [CfgDataW-1:0]         cfg_wdata;
  logic                        in_valid;
  logic                        in_ready;
  logic [PosW-1:0]             position;
  logic                        out_valid;
  logic                        out_ready;
  logic [SpeedW-1:0]           left_speed;
  logic [SpeedW-1:0]           right_speed;
  logic signed [SteerW-1:0]    steer;
  int unsigned                 mismatch_cnt;
  int unsigned                 pending;
  int unsigned                 stall_cycles;
  bit                          quiet_tail;

  pid_differential_steering_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .position_i   (position),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .left_speed_o (left_speed),
    .right_speed_o(right_speed),
    .steer_o      (steer)
  );

  pid_differential_steering_unit_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .position_i    (position),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .left_speed_i  (left_speed),
    .right_speed_i (right_speed),
    .steer_i       (steer),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stall_cycles = 0;
    wait (stall_cycles >= WatchdogLimit);
    $display("Some tests failed");
    $finish;
  end

  // result side: ready runs with stall bursts, none in the tail
  initial begin : sink
    int unsigned run_len;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      run_len = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      repeat (run_len) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      if (!quiet_tail) begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
    end
  end

  task automatic send_position(input logic [PosW-1:0] pos);
    int unsigned gap;
    gap = (quiet_tail || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 6);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    position <= pos;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and hold until every wheel word has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [PosW-1:0] sp, input logic [SpeedW-1:0] ms);
    logic [CfgDataW-1:0] word;
    word              = CfgDataW'($urandom);
    word[SpeedW-1:0]  = ms;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= RegSetpoint;
    cfg_wdata <= sp;
    @(negedge clk);
    cfg_addr  <= RegMaxSpeed;
    cfg_wdata <= word;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [PosW-1:0] pick_position(input logic [PosW-1:0] center);
    int p;
    if ($urandom_range(0, 99) < 15) return PosW'($urandom_range(0, 8191));
    p = int'(center) + int'($urandom_range(0, 800)) - 400;
    if (p < 0) p = 0;
    if (p > 8191) p = 8191;
    return PosW'(p);
  endfunction

  initial begin : stimulus
    int unsigned     phase;
    int unsigned     n;
    logic [PosW-1:0] sp;
    logic [SpeedW-1:0] ms;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = RegSetpoint;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    position   = '0;
    quiet_tail = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: centered word, near center, both extremes
    send_position(13'd3200);
    send_position(13'd3201);
    send_position(13'd3199);
    send_position(13'd0);
    send_position(13'd8191);
    send_position(13'd7000);
    send_position(13'd8191);
    send_position(13'd0);
    settle();
    apply_settings(13'd0, 8'd0);
    send_position(13'd8191);
    send_position(13'd0);
    send_position(13'd1);
    settle();
    apply_settings(13'd8191, 8'd255);
    send_position(13'd0);
    send_position(13'd8191);
    send_position(13'd4096);
    send_position(13'd0);
    settle();
    apply_settings(13'd7000, 8'd1);
    send_position(13'd7000);
    send_position(13'd6999);
    send_position(13'd7001);
    send_position(13'd8191);
    settle();

    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin sp = '0; ms = 8'd255; end
        1: begin sp = 13'd8191; ms = '0; end
        2: begin sp = 13'd7000; ms = 8'd1; end
        default: begin
          sp = PosW'($urandom_range(0, 8191));
          ms = SpeedW'($urandom_range(0, 255));
        end
      endcase
      apply_settings(sp, ms);
      for (n = 0; n < 100; n++) begin
        if (n == 50 && phase[0]) settle();
        send_position(pick_position(sp));
      end
      settle();
    end

    // full rate: hold the error at its positive then negative extreme
    quiet_tail = 1'b1;
    apply_settings(13'd0, 8'd255);
    repeat (15) send_position(13'd8191);
    settle();
    apply_settings(13'd8191, 8'd255);
    repeat (15) send_position(13'd0);
    settle();
    send_position(13'd8191);
    send_position(13'd8000);
    settle();

    if (mismatch_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
